// ===== rtl/tsfp_pkg.sv =====
`timescale 1ns / 1ps

package tsfp_pkg;

    // Buffer bound; positions are counted up to it and value offsets up to one past it
    localparam int MAX_BUFFER_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_BUFFER_BYTES + 2);

    localparam int ID_W    = 16;
    localparam int LEN_W   = 16;
    localparam int OFF_W   = 16;
    localparam int CNT_W   = 15;
    localparam int TDATA_W = 72;

    localparam logic [1:0]       HDR_LAST  = 2'd3;
    localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7FFF;
    localparam logic [OFF_W-1:0] OFF_MAX   = 16'hFFFF;

    localparam logic KIND_FIELD   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_VALUE  = 2'd1,
        PH_PAD    = 2'd2
    } phase_t;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  field_id;
        logic [LEN_W-1:0] value_length;
        logic [OFF_W-1:0] value_offset;
        logic [CNT_W-1:0] field_count;
        logic             truncated;
        logic             overrun;
        logic             last;
    } result_t;

    // Results produced by one accepted beat, in order; num is 0, 1 or 2
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== rtl/tsfp_parser.sv =====
`timescale 1ns / 1ps

module tsfp_parser
    import tsfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat_en,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       end_of_buffer,
    output push_t      push
);

    phase_t           phase_reg, phase_next;
    logic [1:0]       hcount_reg, hcount_next;
    logic [31:0]      shift_reg, shift_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [1:0]       pad_reg, pad_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] vstart_reg, vstart_next;
    logic [CNT_W-1:0] found_reg, found_next;
    logic             ovr_reg, ovr_next;

    logic             at_limit;
    logic             emit;
    logic             trunc;
    logic             off_sat;
    logic [31:0]      vstart_ext;
    result_t          desc;
    result_t          summ;

    assign at_limit = 32'(pos_reg) >= 32'(MAX_BUFFER_BYTES);

    always_comb begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        pad_next    = pad_reg;
        pos_next    = pos_reg;
        vstart_next = vstart_reg;
        ovr_next    = ovr_reg;
        emit        = 1'b0;

        if (byte_valid) begin
            if (at_limit) begin
                ovr_next = 1'b1;
            end
            case (phase_reg)
                PH_VALUE: begin
                    left_next = left_reg - 16'd1;
                    if (left_next == '0) begin
                        emit       = 1'b1;
                        phase_next = (pad_reg != 2'd0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_next == 2'd0) begin
                        phase_next = PH_HEADER;
                    end
                end
                default: begin
                    shift_next = {shift_reg[23:0], data_byte};
                    if (hcount_reg == HDR_LAST) begin
                        hcount_next = 2'd0;
                        vstart_next = pos_reg + POS_W'(1);
                        // pad up to the next multiple of four
                        pad_next    = 2'd0 - shift_next[1:0];
                        if (shift_next[15:0] == '0) begin
                            emit       = 1'b1;
                            phase_next = PH_HEADER;
                        end else begin
                            left_next  = shift_next[15:0];
                            phase_next = PH_VALUE;
                        end
                    end else begin
                        hcount_next = hcount_reg + 2'd1;
                    end
                end
            endcase
            if (!at_limit) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    assign found_next = (emit && found_reg != COUNT_MAX) ? found_reg + 15'd1 : found_reg;

    assign vstart_ext = 32'(vstart_next);
    assign off_sat    = vstart_ext > 32'(OFF_MAX);

    // Buffer ended mid-field; a missing tail of padding does not count
    assign trunc = (phase_next == PH_VALUE) ||
                   (phase_next != PH_PAD && hcount_next != 2'd0);

    always_comb begin
        desc              = '0;
        desc.kind         = KIND_FIELD;
        desc.field_id     = shift_next[31:16];
        desc.value_length = shift_next[15:0];
        desc.value_offset = off_sat ? OFF_MAX : vstart_ext[OFF_W-1:0];
        desc.overrun      = off_sat | ovr_next;
        desc.last         = !end_of_buffer;

        summ             = '0;
        summ.kind        = KIND_SUMMARY;
        summ.field_count = found_next;
        summ.truncated   = trunc;
        summ.overrun     = ovr_next;
        summ.last        = 1'b1;
    end

    always_comb begin
        push     = '0;
        push.num = 2'(emit) + 2'(end_of_buffer);
        push.r0  = emit ? desc : summ;
        push.r1  = summ;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_en && end_of_buffer)) begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            shift_reg  <= '0;
            left_reg   <= '0;
            pad_reg    <= '0;
            pos_reg    <= '0;
            vstart_reg <= '0;
            found_reg  <= '0;
            ovr_reg    <= 1'b0;
        end else if (beat_en) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            shift_reg  <= shift_next;
            left_reg   <= left_next;
            pad_reg    <= pad_next;
            pos_reg    <= pos_next;
            vstart_reg <= vstart_next;
            found_reg  <= found_next;
            ovr_reg    <= ovr_next;
        end
    end

endmodule

// ===== rtl/tsfp_out_queue.sv =====
`timescale 1ns / 1ps

module tsfp_out_queue
    import tsfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_en,
    input  push_t   push,
    output logic    has_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_num;
    logic       pop;

    assign push_num    = push_en ? push.num : 2'd0;
    assign pop         = out_valid && out_ready;
    assign wr_ptr_next = wr_ptr_reg + push_num;
    assign rd_ptr_next = rd_ptr_reg + 2'(pop);
    assign count_next  = count_reg + 3'(push_num) - 3'(pop);

    // Room for the two results of one beat
    assign has_room   = count_reg <= 3'd2;
    assign out_valid  = count_reg != 3'd0;
    assign out_result = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_num != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push_num == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tlv_stream_field_parser_top.sv =====
`timescale 1ns / 1ps

// Parses a buffer of 4-byte aligned TLV fields (big-endian 16-bit id, 16-bit
// length, value zero-padded to a multiple of 4) arriving one byte per beat,
// and emits a descriptor per field and a summary on the tlast beat, after
// which the parser starts over. One input beat is taken every cycle while
// the queue has room; each beat's results land in a four-entry result
// queue. A beat that ends a field and the buffer at once yields two
// results, which leave one per output handshake; s_axis_tready drops
// while the queue holds more than two results, so the input stalls when
// the output cannot keep up. There is no clearing pass after reset.

module tlv_stream_field_parser_top
    import tsfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tuser,   // byte_valid
    input  logic               s_axis_tlast,   // end_of_buffer

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // field_id, value_length, value_offset, field_count, truncated, overrun, zeros
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,   // result_kind
    output logic               m_axis_tlast    // last_result
);

    logic    beat_en;
    logic    has_room;
    push_t   push;
    result_t out_result;

    assign s_axis_tready = has_room;
    assign beat_en       = s_axis_tvalid && has_room;

    tsfp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_en       (beat_en),
        .data_byte     (s_axis_tdata),
        .byte_valid    (s_axis_tuser),
        .end_of_buffer (s_axis_tlast),
        .push          (push)
    );

    tsfp_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (beat_en),
        .push       (push),
        .has_room   (has_room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {7'd0,
                           out_result.overrun,
                           out_result.truncated,
                           out_result.field_count,
                           out_result.value_offset,
                           out_result.value_length,
                           out_result.field_id};
    assign m_axis_tuser = out_result.kind;
    assign m_axis_tlast = out_result.last;

endmodule
